@@ src/overlay_alpha_blend_pixel_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Overlay alpha blend pixel unit: assertion macros
// Shared concurrent assertion forms, all disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef OVERLAY_ALPHA_BLEND_PIXEL_UNIT_MACROS_SVH
`define OVERLAY_ALPHA_BLEND_PIXEL_UNIT_MACROS_SVH

// same-cycle implication
`define OAB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OAB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/oab_pkg.sv @@
// ----------------------------------------------------------------------------
// Overlay alpha blend package
// Formats, conversion coefficients and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package oab_pkg;

  localparam int BYTE_W = 8;
  localparam int PROD_W = 2 * BYTE_W;

  // item latency from accept to done
  localparam int LATENCY = 4;

  typedef enum logic [1:0] {
    FMT_RGB24  = 2'd0,
    FMT_RGBA32 = 2'd1,
    FMT_YV12   = 2'd2
  } fmt_t;

  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  // BT.601 studio range
  localparam logic [PROD_W-1:0] Y_R = 16'd66;
  localparam logic [PROD_W-1:0] Y_G = 16'd129;
  localparam logic [PROD_W-1:0] Y_B = 16'd25;
  localparam logic [PROD_W-1:0] U_R = 16'd38;
  localparam logic [PROD_W-1:0] U_G = 16'd74;
  localparam logic [PROD_W-1:0] U_B = 16'd112;
  localparam logic [PROD_W-1:0] V_R = 16'd112;
  localparam logic [PROD_W-1:0] V_G = 16'd94;
  localparam logic [PROD_W-1:0] V_B = 16'd18;
  localparam logic [PROD_W-1:0] RND = 16'd128;
  // rounding plus 128 << 8 chroma offset
  localparam logic [PROD_W-1:0] C_OFS = 16'd32896;
  localparam logic [BYTE_W-1:0] Y_OFS = 8'd16;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] t;
    t = {1'b0, x} + {{(BYTE_W + 1){1'b0}}, x[PROD_W-1:BYTE_W]} + 17'd1;
    return t[PROD_W-1:BYTE_W];
  endfunction

endpackage

@@ src/oab_mix_lane.sv @@
// ----------------------------------------------------------------------------
// Overlay alpha blend mix lane
// Three-stage (a*s + (255-a)*d) / 255: products, sum, divide.
// ----------------------------------------------------------------------------
module oab_mix_lane (
  input  logic                         clk,
  input  logic [oab_pkg::BYTE_W-1:0]   alpha,
  input  logic [oab_pkg::BYTE_W-1:0]   src,
  input  logic [oab_pkg::BYTE_W-1:0]   dst,
  output logic [oab_pkg::BYTE_W-1:0]   result
);

  logic [oab_pkg::PROD_W-1:0] prod_src;
  logic [oab_pkg::PROD_W-1:0] prod_dst;
  logic [oab_pkg::PROD_W-1:0] sum;
  logic [oab_pkg::PROD_W:0]   sum_next;
  logic [oab_pkg::BYTE_W-1:0] inv_alpha;

  assign inv_alpha = oab_pkg::BYTE_MAX - alpha;
  assign sum_next  = {1'b0, prod_src} + {1'b0, prod_dst};

  always_ff @(posedge clk) begin
    prod_src <= oab_pkg::PROD_W'(alpha) * oab_pkg::PROD_W'(src);
    prod_dst <= oab_pkg::PROD_W'(inv_alpha) * oab_pkg::PROD_W'(dst);
    sum      <= sum_next[oab_pkg::PROD_W-1:0];
    result   <= oab_pkg::div255(sum);
  end

endmodule

@@ src/overlay_alpha_blend_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// Overlay alpha blend pixel unit
// Source-over blend of one BGRA overlay pixel onto an rgb24, rgba32 or
// yv12 destination pixel.
//
//   channel   handshake        payload
//   input     start / busy     src_blue..src_alpha, dst_byte0..dst_byte3
//   result    done             out_byte0..out_byte3
//   config    cfg_we           cfg_wdata (pixel format)
//
// One item per cycle; each result is registered through the conversion,
// products, sum and divide-by-255 stages after its item is accepted.
// busy is always low. rst clears the format register and the valid bits.
// The receiver cannot stall; the format is sampled with each item.
// ----------------------------------------------------------------------------
module overlay_alpha_blend_pixel_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  input  logic [7:0] src_blue,
  input  logic [7:0] src_green,
  input  logic [7:0] src_red,
  input  logic [7:0] src_alpha,
  input  logic [7:0] dst_byte0,
  input  logic [7:0] dst_byte1,
  input  logic [7:0] dst_byte2,
  input  logic [7:0] dst_byte3,
  output logic       done,
  output logic [7:0] out_byte0,
  output logic [7:0] out_byte1,
  output logic [7:0] out_byte2,
  output logic [7:0] out_byte3
);

`include "overlay_alpha_blend_pixel_unit_macros.svh"

  localparam int LANES = 4;

  oab_pkg::fmt_t blend_fmt;

  logic [oab_pkg::LATENCY-1:0] valid;

  // stage 1 registers
  oab_pkg::fmt_t fmt1;
  logic [7:0]    a1, r1, g1, b1, y1, u1, v1;
  logic [7:0]    d1 [LANES];

  logic [15:0] y_sum, u_sum, v_sum;
  logic [7:0]  y_val;

  logic [7:0] lane_alpha [LANES];
  logic [7:0] lane_src   [LANES];
  logic [7:0] lane_dst   [LANES];
  logic [7:0] lane_out   [LANES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_fmt <= oab_pkg::FMT_RGB24;
    end else if (cfg_we) begin
      blend_fmt <= oab_pkg::fmt_t'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[oab_pkg::LATENCY-2:0], start & ~busy};
    end
  end

  assign done = valid[oab_pkg::LATENCY-1];

  // RGB to YUV, all sums stay in 16 bits
  always_comb begin
    y_sum = oab_pkg::Y_R * 16'(src_red) + oab_pkg::Y_G * 16'(src_green)
          + oab_pkg::Y_B * 16'(src_blue) + oab_pkg::RND;
    u_sum = oab_pkg::U_B * 16'(src_blue) + oab_pkg::C_OFS
          - oab_pkg::U_R * 16'(src_red) - oab_pkg::U_G * 16'(src_green);
    v_sum = oab_pkg::V_R * 16'(src_red) + oab_pkg::C_OFS
          - oab_pkg::V_G * 16'(src_green) - oab_pkg::V_B * 16'(src_blue);
    y_val = y_sum[15:8] + oab_pkg::Y_OFS;
  end

  always_ff @(posedge clk) begin
    fmt1  <= blend_fmt;
    a1    <= src_alpha;
    r1    <= src_red;
    g1    <= src_green;
    b1    <= src_blue;
    y1    <= y_val;
    u1    <= u_sum[15:8];
    v1    <= v_sum[15:8];
    d1[0] <= dst_byte0;
    d1[1] <= dst_byte1;
    d1[2] <= dst_byte2;
    d1[3] <= dst_byte3;
  end

  // lane setup; zero lane alpha passes the destination byte through
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      lane_alpha[i] = 8'd0;
      lane_src[i]   = 8'd0;
      lane_dst[i]   = d1[i];
    end
    unique case (fmt1)
      oab_pkg::FMT_RGB24: begin
        lane_alpha[0] = a1;
        lane_alpha[1] = a1;
        lane_alpha[2] = a1;
        lane_src[0]   = r1;
        lane_src[1]   = g1;
        lane_src[2]   = b1;
      end
      oab_pkg::FMT_RGBA32: begin
        // byte 0: a + (255-a)*d/255 is the blend with an opaque source
        lane_alpha[0] = a1;
        lane_alpha[1] = a1;
        lane_alpha[2] = a1;
        lane_alpha[3] = a1;
        lane_src[0]   = oab_pkg::BYTE_MAX;
        lane_src[1]   = b1;
        lane_src[2]   = g1;
        lane_src[3]   = r1;
      end
      oab_pkg::FMT_YV12: begin
        lane_alpha[0] = a1;
        lane_alpha[1] = a1;
        lane_alpha[2] = a1;
        lane_src[0]   = y1;
        lane_src[1]   = u1;
        lane_src[2]   = v1;
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    oab_mix_lane u_lane (
      .clk    (clk),
      .alpha  (lane_alpha[i]),
      .src    (lane_src[i]),
      .dst    (lane_dst[i]),
      .result (lane_out[i])
    );
  end

  assign out_byte0 = lane_out[0];
  assign out_byte1 = lane_out[1];
  assign out_byte2 = lane_out[2];
  assign out_byte3 = lane_out[3];

  `OAB_ASSERT_IMP(a_done_has_item, clk, rst, done,
    $past(start, oab_pkg::LATENCY), "result without an accepted item")
  `OAB_ASSERT_IMP(a_zero_alpha_pass, clk, rst,
    done && $past(src_alpha, oab_pkg::LATENCY) == 8'd0,
    out_byte0 == $past(dst_byte0, oab_pkg::LATENCY) &&
    out_byte1 == $past(dst_byte1, oab_pkg::LATENCY) &&
    out_byte2 == $past(dst_byte2, oab_pkg::LATENCY) &&
    out_byte3 == $past(dst_byte3, oab_pkg::LATENCY),
    "zero alpha item changed the destination")
  `OAB_ASSERT_IMP(a_byte3_pass, clk, rst,
    done && $past(blend_fmt, oab_pkg::LATENCY) != oab_pkg::FMT_RGBA32,
    out_byte3 == $past(dst_byte3, oab_pkg::LATENCY),
    "byte 3 modified outside rgba32")
  `OAB_ASSERT_IMP(a_composite_floor, clk, rst,
    done && $past(blend_fmt, oab_pkg::LATENCY) == oab_pkg::FMT_RGBA32,
    out_byte0 >= $past(src_alpha, oab_pkg::LATENCY),
    "alpha composite below overlay alpha")
  `OAB_ASSERT_NXT(a_item_done, clk, rst, start && !busy,
    valid[0], "accepted item not tracked")

endmodule

@@ verif/tb_overlay_alpha_blend_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// Overlay alpha blend pixel unit testbench
// Sends overlay/destination pixel pairs under every destination format,
// including the unused code, and checks each blended result against an
// in-line predictor. Format writes happen only with no item in flight.
// Source-side gaps are random, with some back-to-back streams.
// ----------------------------------------------------------------------------
module tb_overlay_alpha_blend_pixel_unit;

  localparam logic [1:0] FMT_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic [7:0] dst0;
    logic [7:0] dst1;
    logic [7:0] dst2;
    logic [7:0] dst3;
  } overlay_px_t;

  typedef logic [3:0][7:0] px_bytes_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic [7:0] src_blue;
  logic [7:0] src_green;
  logic [7:0] src_red;
  logic [7:0] src_alpha;
  logic [7:0] dst_byte0;
  logic [7:0] dst_byte1;
  logic [7:0] dst_byte2;
  logic [7:0] dst_byte3;
  logic       done;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;

  px_bytes_t  blended_q[$];
  logic [1:0] fmt_model;
  int         fmt_items[4];
  int         pixels_checked = 0;
  int         mismatches = 0;

  overlay_alpha_blend_pixel_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .src_blue  (src_blue),
    .src_green (src_green),
    .src_red   (src_red),
    .src_alpha (src_alpha),
    .dst_byte0 (dst_byte0),
    .dst_byte1 (dst_byte1),
    .dst_byte2 (dst_byte2),
    .dst_byte3 (dst_byte3),
    .done      (done),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .out_byte3 (out_byte3)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] mix255(input int unsigned a, input int unsigned s,
                                        input int unsigned d);
    return 8'((a * s + (255 - a) * d) / 255);
  endfunction

  function automatic px_bytes_t blend_pixel(input overlay_px_t px, input logic [1:0] fmt);
    int unsigned a, r, g, b, y, u, v;
    px_bytes_t   o;
    a = px.alpha;
    r = px.red;
    g = px.green;
    b = px.blue;
    o = {px.dst3, px.dst2, px.dst1, px.dst0};
    if (a != 0) begin
      unique case (fmt)
        oab_pkg::FMT_RGB24: begin
          o[0] = mix255(a, r, px.dst0);
          o[1] = mix255(a, g, px.dst1);
          o[2] = mix255(a, b, px.dst2);
        end
        oab_pkg::FMT_RGBA32: begin
          o[3] = mix255(a, r, px.dst3);
          o[2] = mix255(a, g, px.dst2);
          o[1] = mix255(a, b, px.dst1);
          o[0] = 8'(a + ((255 - a) * px.dst0) / 255);
        end
        oab_pkg::FMT_YV12: begin
          // chroma keeps a +128<<8 offset so the sum stays positive
          y = (((66 * r + 129 * g + 25 * b + 128) >> 8) + 16) & 8'hff;
          u = ((112 * b + 32896 - 38 * r - 74 * g) >> 8) & 8'hff;
          v = ((112 * r + 32896 - 94 * g - 18 * b) >> 8) & 8'hff;
          o[0] = mix255(a, y, px.dst0);
          o[1] = mix255(a, u, px.dst1);
          o[2] = mix255(a, v, px.dst2);
        end
        default: begin
        end
      endcase
    end
    return o;
  endfunction

  always @(posedge clk) begin : result_check
    px_bytes_t want;
    px_bytes_t got;
    if (rst) begin
      fmt_model = oab_pkg::FMT_RGB24;
    end else begin
      if (start && !busy) begin
        blended_q.push_back(blend_pixel({src_blue, src_green, src_red, src_alpha,
                                         dst_byte0, dst_byte1, dst_byte2, dst_byte3},
                                        fmt_model));
        fmt_items[fmt_model]++;
      end
      if (cfg_we)
        fmt_model = cfg_wdata;
      if (done) begin
        got = {out_byte3, out_byte2, out_byte1, out_byte0};
        if (blended_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, got);
          mismatches++;
        end else begin
          want = blended_q.pop_front();
          pixels_checked++;
          for (int i = 0; i < 4; i++) begin
            if (want[i] !== got[i]) begin
              $display("%0t: out_byte%0d expected %0d actual %0d", $time, i, want[i],
                       got[i]);
              mismatches++;
            end
          end
        end
      end
    end
  end

  task automatic send_pixel(input overlay_px_t px, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    src_blue  <= px.blue;
    src_green <= px.green;
    src_red   <= px.red;
    src_alpha <= px.alpha;
    dst_byte0 <= px.dst0;
    dst_byte1 <= px.dst1;
    dst_byte2 <= px.dst2;
    dst_byte3 <= px.dst3;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (blended_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_format(input logic [1:0] fmt);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic overlay_px_t rand_pixel();
    overlay_px_t px;
    px = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: px.alpha = 8'd0;
      1: px.alpha = 8'd255;
      default: ;
    endcase
    return px;
  endfunction

  // no write yet: reset value must select rgb24
  task automatic test_reset_format();
    send_pixel('{8'h10, 8'h80, 8'hf0, 8'hc0, 8'h20, 8'h40, 8'h60, 8'h99}, 0);
    send_pixel(rand_pixel(), $urandom_range(0, 9));
  endtask

  task automatic test_corner_pixels();
    overlay_px_t corner_px[5];
    logic [1:0]  fmt_order[4];
    corner_px[0] = '{8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00};
    corner_px[1] = '{8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
    corner_px[2] = '{8'hff, 8'h00, 8'h00, 8'h80, 8'h00, 8'hff, 8'h80, 8'hff};
    corner_px[3] = '{8'h00, 8'h00, 8'hff, 8'h01, 8'hff, 8'h00, 8'hff, 8'h00};
    corner_px[4] = '{8'h55, 8'haa, 8'hff, 8'h00, 8'h12, 8'h34, 8'h56, 8'h78};
    fmt_order = '{oab_pkg::FMT_RGBA32, oab_pkg::FMT_YV12, FMT_UNUSED,
                  oab_pkg::FMT_RGB24};
    foreach (fmt_order[f]) begin
      set_format(fmt_order[f]);
      foreach (corner_px[i])
        send_pixel(corner_px[i], $urandom_range(0, 2));
    end
  endtask

  task automatic test_streaming();
    for (int f = 0; f < 4; f++) begin
      set_format(2'(f));
      repeat (25) send_pixel(rand_pixel(), 0);
    end
  endtask

  task automatic test_random_blend();
    logic [1:0] fmt;
    for (int r = 0; r < 15; r++) begin
      fmt = (r < 4) ? 2'(3 - r) : 2'($urandom_range(0, 3));
      set_format(fmt);
      repeat (102) send_pixel(rand_pixel(), $urandom_range(0, 9));
    end
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    src_blue  = '0;
    src_green = '0;
    src_red   = '0;
    src_alpha = '0;
    dst_byte0 = '0;
    dst_byte1 = '0;
    dst_byte2 = '0;
    dst_byte3 = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_format();
    test_corner_pixels();
    test_streaming();
    test_random_blend();

    wait_idle();
    repeat (oab_pkg::LATENCY + 2) @(posedge clk);
    $display("Blended %0d pixels: rgb24 %0d, rgba32 %0d, yv12 %0d, unused format %0d",
             pixels_checked, fmt_items[oab_pkg::FMT_RGB24], fmt_items[oab_pkg::FMT_RGBA32],
             fmt_items[oab_pkg::FMT_YV12], fmt_items[FMT_UNUSED]);
    $display("Mismatches: %0d, results still pending: %0d", mismatches, blended_q.size());
    if (mismatches == 0 && blended_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout with %0d results pending", blended_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
